// ===== sv/tcaot_pkg.sv =====
`default_nettype none

package tcaot_pkg;

  localparam int WINDOW = 5;
  localparam int SAMPLE_W = 12;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int CMP_W = 21;
  localparam int TEMP_SCALE = 330;
  localparam int SET_SCALE = 20;
  localparam int OFFSET_TERM = 266175;

  typedef struct packed {
    logic clear;
    logic accumulate;
    logic step;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/tcaot_in_if.sv =====
`default_nettype none

interface tcaot_in_if;
  logic valid;
  logic ready;
  logic [tcaot_pkg::SAMPLE_W-1:0] temperature_sample;
  logic [tcaot_pkg::SAMPLE_W-1:0] light_sample;
  logic [tcaot_pkg::SAMPLE_W-1:0] setpoint_sample;

  modport source (
    output valid, temperature_sample, light_sample, setpoint_sample,
    input ready
  );
  modport sink (
    input valid, temperature_sample, light_sample, setpoint_sample,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/tcaot_out_if.sv =====
`default_nettype none

interface tcaot_out_if;
  logic valid;
  logic ready;
  logic [tcaot_pkg::SAMPLE_W-1:0] temperature_average;
  logic [tcaot_pkg::SAMPLE_W-1:0] light_average;
  logic [tcaot_pkg::SAMPLE_W-1:0] setpoint_average;
  logic over_setpoint;

  modport source (
    output valid, temperature_average, light_average, setpoint_average, over_setpoint,
    input ready
  );
  modport sink (
    input valid, temperature_average, light_average, setpoint_average, over_setpoint,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/tcaot_ring.sv =====
`default_nettype none

module tcaot_ring #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 5
) (
  input  wire logic                       clk,
  input  wire logic                       write,
  input  wire logic [$clog2(DEPTH)-1:0]   slot,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   idx,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] entry [DEPTH];

  always_ff @(posedge clk) begin
    if (write) begin
      entry[slot] <= wdata;
    end
    rdata <= entry[idx];
  end

endmodule

`default_nettype wire

// ===== sv/tcaot_lane.sv =====
`default_nettype none

module tcaot_lane (
  input  wire logic                              clk,
  input  wire tcaot_pkg::ctl_t                   ctl,
  input  wire logic [tcaot_pkg::SAMPLE_W-1:0]    ring_data,
  input  wire logic [tcaot_pkg::FILL_W-1:0]      divisor,
  output logic      [tcaot_pkg::SAMPLE_W-1:0]    quotient
);

  logic [tcaot_pkg::SUM_W-1:0] acc;
  logic [tcaot_pkg::FILL_W-1:0] rem;
  logic [tcaot_pkg::FILL_W:0] trial;
  logic fits;

  assign trial = {rem, acc[tcaot_pkg::SUM_W-1]};
  assign fits = trial >= {1'b0, divisor};

  // Sum one entry a cycle, then restoring division one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
      rem <= '0;
    end else if (ctl.accumulate) begin
      acc <= acc + tcaot_pkg::SUM_W'(ring_data);
    end else if (ctl.step) begin
      if (fits) begin
        rem <= tcaot_pkg::FILL_W'(trial - {1'b0, divisor});
        acc <= {acc[tcaot_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[tcaot_pkg::FILL_W-1:0];
        acc <= {acc[tcaot_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = acc[tcaot_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== sv/three_channel_average_over_threshold.sv =====
// Each accepted word goes through the registered ring read, the serial sum over the
// filled ring entries and the 15-step bit-serial divider before its result word is
// loaded; no new word is taken until then, since the input is ready only in IDLE.
// A new word is taken while the previous result still waits in the output register.
// Reset clears write slot, fill count, sequencer and output valid; ring contents are
// not cleared and are read only after being written.
`default_nettype none

module three_channel_average_over_threshold (
  input  wire logic        clk,
  input  wire logic        rst,
  tcaot_in_if.sink         samples,
  tcaot_out_if.source      averages
);

  typedef enum logic [1:0] {
    IDLE,
    SUM,
    DIV,
    FINISH
  } state_t;

  state_t state;
  logic [tcaot_pkg::SLOT_W-1:0] slot;
  logic [tcaot_pkg::FILL_W-1:0] fill;
  logic [tcaot_pkg::SLOT_W-1:0] idx;
  logic [tcaot_pkg::STEP_W-1:0] cnt;
  logic rd_valid;
  logic out_valid;
  logic [tcaot_pkg::SAMPLE_W-1:0] t_out;
  logic [tcaot_pkg::SAMPLE_W-1:0] l_out;
  logic [tcaot_pkg::SAMPLE_W-1:0] s_out;
  logic over_out;

  logic accept;
  tcaot_pkg::ctl_t ctl;
  logic [tcaot_pkg::SAMPLE_W-1:0] t_rd, l_rd, s_rd;
  logic [tcaot_pkg::SAMPLE_W-1:0] t_q, l_q, s_q;
  logic [tcaot_pkg::CMP_W-1:0] lhs, rhs;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (state == IDLE);

  always_comb begin
    ctl = '0;
    ctl.clear = accept;
    ctl.accumulate = rd_valid;
    ctl.step = (state == DIV) && !rd_valid;
  end

  tcaot_ring #(.WIDTH(tcaot_pkg::SAMPLE_W), .DEPTH(tcaot_pkg::WINDOW)) u_t_ring (
    .clk(clk), .write(accept), .slot(slot), .wdata(samples.temperature_sample),
    .idx(idx), .rdata(t_rd)
  );
  tcaot_ring #(.WIDTH(tcaot_pkg::SAMPLE_W), .DEPTH(tcaot_pkg::WINDOW)) u_l_ring (
    .clk(clk), .write(accept), .slot(slot), .wdata(samples.light_sample),
    .idx(idx), .rdata(l_rd)
  );
  tcaot_ring #(.WIDTH(tcaot_pkg::SAMPLE_W), .DEPTH(tcaot_pkg::WINDOW)) u_s_ring (
    .clk(clk), .write(accept), .slot(slot), .wdata(samples.setpoint_sample),
    .idx(idx), .rdata(s_rd)
  );

  tcaot_lane u_t_lane (
    .clk(clk), .ctl(ctl), .ring_data(t_rd), .divisor(fill), .quotient(t_q)
  );
  tcaot_lane u_l_lane (
    .clk(clk), .ctl(ctl), .ring_data(l_rd), .divisor(fill), .quotient(l_q)
  );
  tcaot_lane u_s_lane (
    .clk(clk), .ctl(ctl), .ring_data(s_rd), .divisor(fill), .quotient(s_q)
  );

  assign lhs = tcaot_pkg::CMP_W'(t_q) * tcaot_pkg::CMP_W'(tcaot_pkg::TEMP_SCALE);
  assign rhs = tcaot_pkg::CMP_W'(s_q) * tcaot_pkg::CMP_W'(tcaot_pkg::SET_SCALE)
             + tcaot_pkg::CMP_W'(tcaot_pkg::OFFSET_TERM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      slot <= '0;
      fill <= '0;
      idx <= '0;
      cnt <= '0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= (state == SUM);
      if (out_valid && averages.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            if (fill != tcaot_pkg::FILL_W'(tcaot_pkg::WINDOW)) begin
              fill <= fill + 1'b1;
            end
            if (slot == tcaot_pkg::SLOT_W'(tcaot_pkg::WINDOW - 1)) begin
              slot <= '0;
            end else begin
              slot <= slot + 1'b1;
            end
            idx <= '0;
            state <= SUM;
          end
        end
        SUM: begin
          if (tcaot_pkg::FILL_W'(idx) + 1'b1 == fill) begin
            cnt <= tcaot_pkg::STEP_W'(tcaot_pkg::SUM_W);
            state <= DIV;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        DIV: begin
          if (cnt == '0) begin
            state <= FINISH;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        FINISH: begin
          if (!out_valid || averages.ready) begin
            t_out <= t_q;
            l_out <= l_q;
            s_out <= s_q;
            over_out <= lhs > rhs;
            out_valid <= 1'b1;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign averages.valid = out_valid;
  assign averages.temperature_average = t_out;
  assign averages.light_average = l_out;
  assign averages.setpoint_average = s_out;
  assign averages.over_setpoint = over_out;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= tcaot_pkg::FILL_W'(tcaot_pkg::WINDOW))
    else $error("fill count above window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot <= tcaot_pkg::SLOT_W'(tcaot_pkg::WINDOW - 1))
    else $error("write slot out of range");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (fill == $past(fill) + 1'b1) || (fill == tcaot_pkg::FILL_W'(tcaot_pkg::WINDOW)))
    else $error("fill count did not advance");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == FINISH)
    else $error("result word loaded outside finish");
`endif

endmodule

`default_nettype wire
